FILE: hdl/nps_pkg.sv
`default_nettype none

package nps_pkg;

   localparam int ID_W    = 8;
   localparam int PRIO_W  = 8;
   localparam int BURST_W = 16;
   localparam int TIME_W  = 32;
   localparam int STAT_W  = 2;

   // operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_ADDED = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_RUN   = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_IDLE  = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic              capture;    // latch the request item
      logic              seek_step;  // advance the free-slot pointer
      logic              add_write;  // store the job at the pointer slot
      logic              remove;     // drop the finished current job
      logic              scan_init;  // restart the selection scan
      logic              scan_step;  // one read of the selection scan
      logic              load_cur;   // make the scan winner current
      logic              run;        // run the current job for one slice
      logic              set_res;    // result with status only
      logic [STAT_W-1:0] res_code;
      logic              rsp_load;   // move result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic slot_free;
      logic has_cur;
      logic cur_zero;
      logic scan_done;
      logic found;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: hdl/nps_ctrl.sv
`default_nettype none

module nps_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   input  wire               req_op,
   output logic              req_tready,
   input  nps_pkg::stat_type stat,
   output nps_pkg::cmd_type  cmd
);
   import nps_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEEK   = 6'b000010,
      ST_CHECK  = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_RUN    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = (req_op == OP_TICK) ? ST_CHECK : ST_SEEK;
            end
         end
         ST_SEEK: begin
            if (stat.full) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = STATUS_FULL;
               state_in     = ST_FINISH;
            end else if (stat.slot_free) begin
               cmd.add_write = 1'b1;
               cmd.set_res   = 1'b1;
               cmd.res_code  = STATUS_ADDED;
               state_in      = ST_FINISH;
            end else begin
               cmd.seek_step = 1'b1;
            end
         end
         ST_CHECK: begin
            if (stat.has_cur && !stat.cur_zero) begin
               state_in = ST_RUN;
            end else begin
               cmd.remove    = stat.has_cur;
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               if (stat.found) begin
                  cmd.load_cur = 1'b1;
                  state_in     = ST_RUN;
               end else begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = STATUS_IDLE;
                  state_in     = ST_FINISH;
               end
            end
         end
         ST_RUN: begin
            cmd.run  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   a_capture_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_SEEK || state_ff == ST_CHECK))
      else $error("accepted item did not start work");
`endif

endmodule

`default_nettype wire

FILE: hdl/nps_dp.sv
`default_nettype none

module nps_dp #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire  [79:0]       req_tdata,
   input  nps_pkg::cmd_type  cmd,
   output nps_pkg::stat_type stat,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [95:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser
);
   import nps_pkg::*;

   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_W = ID_W + PRIO_W + BURST_W + SLOT_W;
   localparam int BURST_LO = SLOT_W;
   localparam int PRIO_LO  = SLOT_W + BURST_W;
   localparam int ID_LO    = SLOT_W + BURST_W + PRIO_W;

   // entry memory: {tag, priority, burst, rank}
   logic [WORD_W-1:0] entry_mem_ff [TABLE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic              mem_re;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       add_cnt_ff, add_cnt_in;

   // latched request
   logic [ID_W-1:0]    rq_tag_ff;
   logic [PRIO_W-1:0]  rq_prio_ff;
   logic [BURST_W-1:0] rq_burst_ff;
   logic [TIME_W-1:0]  rq_now_ff;
   logic [BURST_W-1:0] rq_slice_ff;

   // slot pointer shared by the free-slot seek and the selection scan
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [SLOT_W-1:0] ptr_idx;
   logic              ptr_end;
   logic              rd_pend_ff;
   logic [SLOT_W-1:0] rd_slot_ff;

   // rank close-up after a removal
   logic              rm_active_ff;
   logic [SLOT_W-1:0] rm_rank_ff;

   // scan best-so-far
   logic               found_ff;
   logic [SLOT_W-1:0]  best_slot_ff;
   logic [PRIO_W-1:0]  best_prio_ff;
   logic [SLOT_W-1:0]  best_ord_ff;
   logic [ID_W-1:0]    best_tag_ff;
   logic [BURST_W-1:0] best_burst_ff;

   // current job
   logic               has_cur_ff;
   logic [SLOT_W-1:0]  cur_slot_ff;
   logic [SLOT_W-1:0]  cur_rank_ff;
   logic [ID_W-1:0]    cur_tag_ff;
   logic [BURST_W-1:0] cur_burst_ff;
   logic [BURST_W-1:0] cur_rem_ff;
   logic [TIME_W-1:0]  cur_start_ff;

   // staged result and output register
   logic [STAT_W-1:0]  res_status_ff, rsp_status_ff;
   logic [ID_W-1:0]    res_id_ff, rsp_id_ff;
   logic [BURST_W-1:0] res_rem_ff, rsp_rem_ff;
   logic [TIME_W-1:0]  res_start_ff, rsp_start_ff;
   logic [TIME_W-1:0]  res_end_ff, rsp_end_ff;
   logic               res_done_ff, rsp_done_ff;
   logic               rsp_valid_ff;

   // scan compare stage
   logic [SLOT_W-1:0]  rd_ord, ord_adj;
   logic [PRIO_W-1:0]  rd_prio;
   logic               rd_live, rd_shift, better;

   // run arithmetic
   logic [BURST_W-1:0] rem_new;
   logic [TIME_W-1:0]  start_new;
   logic               run_done;

   assign ptr_idx = ptr_ff[SLOT_W-1:0];
   assign ptr_end = (ptr_ff == CNT_W'(TABLE_DEPTH));

   assign rd_ord   = rd_data_ff[SLOT_W-1:0];
   assign rd_prio  = rd_data_ff[PRIO_LO +: PRIO_W];
   assign rd_live  = rd_pend_ff && valid_ff[rd_slot_ff];
   assign rd_shift = rd_live && rm_active_ff && (rd_ord > rm_rank_ff);
   assign ord_adj  = rd_shift ? rd_ord - SLOT_W'(1) : rd_ord;
   assign better   = rd_live && (!found_ff || (rd_prio < best_prio_ff) ||
                     ((rd_prio == best_prio_ff) && (ord_adj < best_ord_ff)));

   assign mem_re = cmd.scan_step && !ptr_end;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ptr_idx;
      mem_wdata = {rq_tag_ff, rq_prio_ff, rq_burst_ff, add_cnt_ff[SLOT_W-1:0]};
      if (cmd.add_write) begin
         mem_we = 1'b1;
      end else if (rd_shift) begin
         mem_we    = 1'b1;
         mem_waddr = rd_slot_ff;
         mem_wdata = {rd_data_ff[WORD_W-1:SLOT_W], ord_adj};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem_ff[ptr_idx];
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      add_cnt_in = add_cnt_ff;
      if (cmd.add_write) begin
         valid_in[ptr_idx] = 1'b1;
         add_cnt_in        = add_cnt_ff + CNT_W'(1);
      end
      if (cmd.remove) begin
         valid_in[cur_slot_ff] = 1'b0;
         add_cnt_in            = add_cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.capture || cmd.scan_init) begin
         ptr_in = '0;
      end else if (cmd.seek_step || mem_re) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
   end

   always_comb begin
      start_new = (cur_rem_ff == cur_burst_ff) ? rq_now_ff : cur_start_ff;
      rem_new   = (cur_rem_ff > rq_slice_ff) ? cur_rem_ff - rq_slice_ff : '0;
      run_done  = (rem_new == '0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         add_cnt_ff   <= '0;
         ptr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rm_active_ff <= 1'b0;
         found_ff     <= 1'b0;
         has_cur_ff   <= 1'b0;
         cur_slot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         add_cnt_ff <= add_cnt_in;
         ptr_ff     <= ptr_in;
         rd_pend_ff <= mem_re;
         if (cmd.capture) begin
            rm_active_ff <= 1'b0;
         end else if (cmd.remove) begin
            rm_active_ff <= 1'b1;
         end
         if (cmd.scan_init) begin
            found_ff <= 1'b0;
         end else if (better) begin
            found_ff <= 1'b1;
         end
         if (cmd.remove) begin
            has_cur_ff <= 1'b0;
         end else if (cmd.load_cur) begin
            has_cur_ff  <= 1'b1;
            cur_slot_ff <= best_slot_ff;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rq_tag_ff   <= req_tdata[7:0];
         rq_prio_ff  <= req_tdata[15:8];
         rq_burst_ff <= req_tdata[31:16];
         rq_now_ff   <= req_tdata[63:32];
         rq_slice_ff <= req_tdata[79:64];
      end
      rd_slot_ff <= ptr_idx;
      if (cmd.remove) begin
         rm_rank_ff <= cur_rank_ff;
      end
      if (better) begin
         best_slot_ff  <= rd_slot_ff;
         best_prio_ff  <= rd_prio;
         best_ord_ff   <= ord_adj;
         best_tag_ff   <= rd_data_ff[ID_LO +: ID_W];
         best_burst_ff <= rd_data_ff[BURST_LO +: BURST_W];
      end
      if (cmd.load_cur) begin
         cur_rank_ff  <= best_ord_ff;
         cur_tag_ff   <= best_tag_ff;
         cur_burst_ff <= best_burst_ff;
         cur_rem_ff   <= best_burst_ff;
         cur_start_ff <= '0;
      end else if (cmd.run) begin
         cur_rem_ff   <= rem_new;
         cur_start_ff <= start_new;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_code;
         res_id_ff     <= '0;
         res_rem_ff    <= '0;
         res_start_ff  <= '0;
         res_end_ff    <= '0;
         res_done_ff   <= 1'b0;
      end else if (cmd.run) begin
         res_status_ff <= STATUS_RUN;
         res_id_ff     <= cur_tag_ff;
         res_rem_ff    <= rem_new;
         res_start_ff  <= start_new;
         res_end_ff    <= run_done ? rq_now_ff : '0;
         res_done_ff   <= run_done;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_rem_ff    <= res_rem_ff;
         rsp_start_ff  <= res_start_ff;
         rsp_end_ff    <= res_end_ff;
         rsp_done_ff   <= res_done_ff;
      end
   end

   always_comb begin
      stat.full      = (add_cnt_ff == CNT_W'(TABLE_DEPTH));
      stat.slot_free = !ptr_end && !valid_ff[ptr_idx];
      stat.has_cur   = has_cur_ff;
      stat.cur_zero  = (cur_rem_ff == '0);
      stat.scan_done = ptr_end && !rd_pend_ff;
      stat.found     = found_ff;
      stat.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_done_ff, rsp_end_ff, rsp_start_ff, rsp_rem_ff, rsp_id_ff};

`ifndef NO_ASSERTIONS
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(add_cnt_ff))
      else $error("live count differs from valid bits");

   a_current_is_live: assert property (@(posedge clock) disable iff (reset)
      has_cur_ff |-> valid_ff[cur_slot_ff])
      else $error("current job slot not valid");
`endif

endmodule

`default_nettype wire

FILE: hdl/nonpreemptive_priority_scheduler_unit.sv
`default_nettype none

// Channel  Dir  Ports              Payload
// req      in   req_tvalid/tready  tuser: operation; tdata: job fields
// rsp      out  rsp_tvalid/tready  tuser: status; tdata: run fields
//
// Add: the seek steps past each occupied slot ahead of the lowest free one,
// or reports full. A tick that keeps the running job goes check, run, finish.
// A tick that selects a job first scans every slot of the entry memory, one
// read per cycle, and ends idle if none is live. Reset clears the valid bits,
// live count and current job; no clearing pass. The result waits in an output
// register, and the next item is taken meanwhile; finishing the next item
// stalls until it drains.

module nonpreemptive_priority_scheduler_unit #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [7:0] job_id, [15:8] job_priority, [31:16] job_burst,
   // [63:32] current_time, [79:64] time_slice
   input  wire  [79:0] req_tdata,
   // [0] operation
   input  wire  [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [7:0] run_id, [23:8] run_remaining, [55:24] run_start,
   // [87:56] run_end, [88] run_done, [95:89] zero
   output logic [95:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser
);
   import nps_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing: idle, seek free slot, check current, scan, run, finish
   nps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser[0]),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // entry memory, valid bits, current job and result registers
   nps_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import nps_pkg::*;

   localparam int SLOTS         = 16;
   localparam int HOLD_CYCLES   = 500;   // long receiver hold-off
   localparam int STALL_LIMIT   = 4000;  // cycles without any handshake
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic               op;
      logic [ID_W-1:0]    tag;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
      logic [TIME_W-1:0]  now;
      logic [BURST_W-1:0] slice;
   } job_req_type;

   // field order matches {rsp_tuser, rsp_tdata fields from the low end up}
   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [ID_W-1:0]    tag;
      logic [BURST_W-1:0] left;
      logic [TIME_W-1:0]  started;
      logic [TIME_W-1:0]  finished;
      logic               done;
      logic [6:0]         pad;
   } run_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [79:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [95:0] rsp_tdata;
   wire  [1:0]  rsp_tuser;

   nonpreemptive_priority_scheduler_unit #(
      .TABLE_DEPTH(SLOTS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Job table mirror
   // ---------------------------------------------------------------
   logic               slot_live  [SLOTS];
   logic [15:0]        slot_rank  [SLOTS];   // add-order rank among live jobs
   logic [ID_W-1:0]    slot_tag   [SLOTS];
   logic [PRIO_W-1:0]  slot_prio  [SLOTS];
   logic [BURST_W-1:0] slot_burst [SLOTS];
   logic [BURST_W-1:0] slot_left  [SLOTS];
   logic [TIME_W-1:0]  slot_start [SLOTS];
   int                 cur_slot;
   logic               cur_valid;
   logic [15:0]        live_count;

   run_report_type sched_expected_q[$];

   int          send_idle_pct = 0;
   int          rsp_idle_pct  = 0;
   int          hold_requests = 0;
   int          hold_served   = 0;
   int          hold_left     = 0;
   int          error_count   = 0;
   int          quiet_cycles  = 0;
   logic [31:0] sim_now       = '0;

   function automatic void clear_job_table();
      int i;
      for (i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
      cur_slot   = 0;
      cur_valid  = 1'b0;
      live_count = '0;
   endfunction

   function automatic run_report_type predict_schedule(job_req_type it);
      run_report_type     r;
      int                 i;
      int                 free_slot;
      int                 best;
      logic [15:0]        gone_rank;
      logic [BURST_W-1:0] rem;
      r = '0;
      if (it.op == OP_ADD) begin
         free_slot = -1;
         for (i = SLOTS - 1; i >= 0; i--)
            if (!slot_live[i]) free_slot = i;
         if (free_slot < 0) begin
            r.status = STATUS_FULL;
            return r;
         end
         slot_live[free_slot]  = 1'b1;
         slot_rank[free_slot]  = live_count;
         slot_tag[free_slot]   = it.tag;
         slot_prio[free_slot]  = it.prio;
         slot_burst[free_slot] = it.burst;
         slot_left[free_slot]  = it.burst;
         slot_start[free_slot] = '0;
         live_count            = live_count + 16'd1;
         r.status = STATUS_ADDED;
         return r;
      end

      if (cur_valid && !slot_live[cur_slot]) cur_valid = 1'b0;

      // job that finished on an earlier tick leaves now; younger ranks close up
      if (cur_valid && slot_left[cur_slot] == '0) begin
         gone_rank = slot_rank[cur_slot];
         slot_live[cur_slot] = 1'b0;
         for (i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_rank[i] > gone_rank) slot_rank[i] = slot_rank[i] - 16'd1;
         if (live_count != '0) live_count = live_count - 16'd1;
         cur_valid = 1'b0;
      end

      if (!cur_valid) begin
         best = -1;
         for (i = 0; i < SLOTS; i++)
            if (slot_live[i] && (best < 0 || slot_prio[i] < slot_prio[best] ||
                (slot_prio[i] == slot_prio[best] && slot_rank[i] < slot_rank[best])))
               best = i;
         if (best < 0) begin
            r.status = STATUS_IDLE;
            return r;
         end
         cur_slot  = best;
         cur_valid = 1'b1;
      end

      // untouched job (left == burst) gets its start stamp, even on a zero slice
      if (slot_left[cur_slot] == slot_burst[cur_slot]) slot_start[cur_slot] = it.now;
      rem = (slot_left[cur_slot] > it.slice) ? slot_left[cur_slot] - it.slice : '0;
      slot_left[cur_slot] = rem;
      r.status  = STATUS_RUN;
      r.tag     = slot_tag[cur_slot];
      r.left    = rem;
      r.started = slot_start[cur_slot];
      if (rem == '0) begin
         r.finished = it.now;
         r.done     = 1'b1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Item builders
   // ---------------------------------------------------------------
   // unused fields of an item still carry random bits
   function automatic job_req_type random_fields();
      job_req_type it;
      it.op    = 1'($urandom_range(1));
      it.tag   = ID_W'($urandom);
      it.prio  = PRIO_W'($urandom);
      it.burst = BURST_W'($urandom);
      it.now   = $urandom;
      it.slice = BURST_W'($urandom);
      return it;
   endfunction

   function automatic job_req_type add_item(logic [ID_W-1:0] tag, logic [PRIO_W-1:0] prio,
                                            logic [BURST_W-1:0] burst);
      job_req_type it;
      it       = random_fields();
      it.op    = OP_ADD;
      it.tag   = tag;
      it.prio  = prio;
      it.burst = burst;
      return it;
   endfunction

   function automatic job_req_type tick_item(logic [TIME_W-1:0] now,
                                             logic [BURST_W-1:0] slice);
      job_req_type it;
      it       = random_fields();
      it.op    = OP_TICK;
      it.now   = now;
      it.slice = slice;
      return it;
   endfunction

   // short bursts and small slices so jobs finish; narrow priorities for ties
   function automatic job_req_type random_job_item(int add_pct);
      job_req_type it;
      int          pick;
      it    = random_fields();
      it.op = ($urandom_range(99) < add_pct) ? OP_ADD : OP_TICK;
      if ($urandom_range(99) < 50) it.prio = PRIO_W'($urandom_range(3));
      it.burst = BURST_W'(($urandom_range(99) < 80) ? $urandom_range(1, 6)
                                                     : $urandom_range(1, 65535));
      pick = $urandom_range(99);
      if (pick < 70)      it.slice = BURST_W'($urandom_range(1, 4));
      else if (pick < 95) it.slice = BURST_W'($urandom_range(1, 65535));
      else                it.slice = 16'hFFFF;
      sim_now = sim_now + $urandom_range(0, 9);
      if ($urandom_range(99) >= 10) it.now = sim_now;
      return it;
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   task automatic send_item(input job_req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {it.slice, it.now, it.burst, it.prio, it.tag};
      do @(posedge clock); while (!req_tready);
      sched_expected_q = {sched_expected_q, predict_schedule(it)};
   endtask

   // sender goes quiet until every pending result has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (sched_expected_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Result side: check accepted items, then pick next tready
   // ---------------------------------------------------------------
   function automatic string show_report(run_report_type r);
      return $sformatf("status=%0d id=%02h left=%04h start=%08h end=%08h done=%0b pad=%02h",
                       r.status, r.tag, r.left, r.started, r.finished, r.done, r.pad);
   endfunction

   always @(posedge clock) begin
      run_report_type got;
      run_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8], rsp_tdata[55:24],
                rsp_tdata[87:56], rsp_tdata[88], rsp_tdata[95:89]};
         if (sched_expected_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: result with nothing pending: %s", $realtime, show_report(got));
         end else begin
            want = sched_expected_q.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: result mismatch", $realtime);
                  $display("   expected %s", show_report(want));
                  $display("   actual   %s", show_report(got));
               end
            end
         end
      end
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // no handshake on either side for too long -> hung
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      int n;
      send_idle_pct = 0;
      rsp_idle_pct  = 30;
      send_item(tick_item(32'd100, 16'd1));            // empty table: idle
      send_item(add_item(8'h00, 8'hFF, 16'hFFFF));     // worst priority, longest burst
      send_item(add_item(8'hFF, 8'h00, 16'h0001));
      send_item(add_item(8'h5A, 8'h00, 16'h0000));     // zero burst, ties with 8'hFF
      send_item(tick_item(32'd0, 16'hFFFF));           // older tie wins, finishes
      send_item(tick_item(32'hFFFF_FFFF, 16'd0));      // zero slice on zero left: done
      send_item(tick_item(32'd7, 16'd0));              // zero slice, left stays full
      send_item(tick_item(32'd9, 16'd0));              // start stamp taken again
      send_item(add_item(8'hA5, 8'h00, 16'd3));        // better priority, no preemption
      send_item(tick_item(32'd11, 16'hFFFF));          // running job still runs
      // fill every free slot, then overflow
      for (n = 0; n < SLOTS - 2; n++)
         send_item(add_item(ID_W'($urandom), PRIO_W'($urandom_range(1)),
                            BURST_W'($urandom_range(1, 4))));
      send_item(add_item(8'h77, 8'h00, 16'd1));        // table full: dropped
      wait_results_drained();
   endtask

   task automatic test_random_traffic(int send_pct, int rsp_pct, int count);
      int n;
      int add_pct;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      add_pct       = 50;
      for (n = 0; n < count; n++) begin
         // alternate filling and draining stretches
         if (n % 24 == 0) add_pct = $urandom_range(1) ? 80 : 30;
         send_item(random_job_item(add_pct));
      end
   endtask

   // receiver stops for a long stretch while items keep coming
   task automatic test_receiver_holdoff();
      int n;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_requests++;
      for (n = 0; n < 30; n++) send_item(random_job_item(60));
      wait_results_drained();
   endtask

   initial begin
      clear_job_table();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(20, 75, 270);
      test_receiver_holdoff();
      test_random_traffic(75, 20, 260);
      wait_results_drained();
      test_random_traffic(0, 0, 270);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && sched_expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: nonpreemptive_priority_scheduler_unit.f
hdl/nps_pkg.sv
hdl/nps_ctrl.sv
hdl/nps_dp.sv
hdl/nonpreemptive_priority_scheduler_unit.sv
bench/tb_top.sv
